// ===== rtl/ltkm_pkg.sv =====
// shared constants and controller/datapath interface types for the loser tree merge
`timescale 1ns / 1ps

package ltkm_pkg;

  // field widths
  localparam int KEY_W  = 32;
  localparam int INFO_W = 32;
  localparam int RUN_W  = 6;

  // default number of input runs
  localparam int NUM_RUNS_DEF = 8;

  // end-of-run sentinel key
  localparam logic signed [KEY_W-1:0] KEY_END = 32'sh7fff_ffff;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // input item taken this cycle
    logic merging;   // block is in the merging phase
    logic rd_champ;  // read the climbing leaf record
    logic cap;       // capture climbing record, set first node
    logic rd_slot;   // read the loser slot of the current node
    logic rd_other;  // read the leaf record of that loser
    logic step;      // compare and move one level up
    logic emit;      // load the output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic load_full;   // the item being loaded is the last head record
    logic at_top;      // current node is the last one below the root
    logic more_build;  // tree build has leaves left to replay
    logic is_end;      // winner holds the sentinel key
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

// ===== rtl/loser_tree_kway_merge_core.sv =====
// top level of the k-way loser tree merge: controller, datapath and checks
`timescale 1ns / 1ps

// Merges NUM_RUNS sorted runs of (key, info) records into one sorted run.
// The first NUM_RUNS items load the head records of runs 0 to NUM_RUNS-1 and
// give no result; the last of them builds the tree and one result follows.
// Every later item must be the next record of the run named by the last
// src_run, and gives one result. A run ends with key 0x7fffffff; when that
// key wins, the result carries last = 1 and the next item starts a new
// merge at run 0. A merging item climbs the tree from its leaf; at each
// level it reads the loser slot memory, then the leaf record memory, then
// compares, one registered read per cycle. The build after the last head
// record replays every leaf in turn. The result sits in an output
// register, so the next item is taken while a result is still stalled.

module loser_tree_kway_merge_core #(
  parameter int NUM_RUNS = ltkm_pkg::NUM_RUNS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ltkm_pkg::KEY_W-1:0]   key,
  input  logic signed [ltkm_pkg::INFO_W-1:0]  info,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ltkm_pkg::KEY_W-1:0]   out_key,
  output logic signed [ltkm_pkg::INFO_W-1:0]  out_info,
  output logic [ltkm_pkg::RUN_W-1:0]          src_run,
  output logic                                last
);

  ltkm_pkg::cmd_t cmd;
  ltkm_pkg::sts_t sts;

  // sequencing
  ltkm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and compare
  ltkm_dpath #(
    .NUM_RUNS (NUM_RUNS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .key       (key),
    .info      (info),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_key   (out_key),
    .out_info  (out_info),
    .src_run   (src_run),
    .last      (last)
  );

  // a result is loaded only into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result loaded over a pending result");

  // at most one datapath command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.rd_champ, cmd.cap, cmd.rd_slot, cmd.rd_other,
              cmd.step, cmd.emit}))
    else $error("overlapping datapath commands");

  // each level read is followed by its compare
  a_level_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_other |=> cmd.step)
    else $error("level compare did not follow its reads");

  // no item is taken while a replay is in progress
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.cap |=> in_stall)
    else $error("input taken during a replay");

endmodule

// ===== rtl/ltkm_ctrl.sv =====
// controller state machine: loading, tree replay sequencing and result hand-off
`timescale 1ns / 1ps

module ltkm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  ltkm_pkg::sts_t  sts,
  output ltkm_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b000_0001,
    S_RDCH = 7'b000_0010,
    S_CAP  = 7'b000_0100,
    S_RDSL = 7'b000_1000,
    S_RDOT = 7'b001_0000,
    S_CMP  = 7'b010_0000,
    S_EMIT = 7'b100_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   merging;
  logic   merging_next;

  // input is taken only between replays
  assign in_stall = (state != S_IDLE);

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.accept   = (state == S_IDLE) && in_valid;
    cmd.merging  = merging;
    cmd.rd_champ = (state == S_RDCH);
    cmd.cap      = (state == S_CAP);
    cmd.rd_slot  = (state == S_RDSL);
    cmd.rd_other = (state == S_RDOT);
    cmd.step     = (state == S_CMP);
    cmd.emit     = (state == S_EMIT) && sts.out_free;
  end

  // next state
  always_comb begin
    state_next   = state;
    merging_next = merging;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (merging) begin
            state_next = S_RDCH;
          end else if (sts.load_full) begin
            state_next   = S_RDCH;
            merging_next = 1'b1;
          end
        end
      end
      S_RDCH: state_next = S_CAP;
      S_CAP:  state_next = S_RDSL;
      S_RDSL: state_next = S_RDOT;
      S_RDOT: state_next = S_CMP;
      S_CMP: begin
        if (!sts.at_top) begin
          state_next = S_RDSL;
        end else if (sts.more_build) begin
          state_next = S_RDCH;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
          if (sts.is_end) begin
            merging_next = 1'b0;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      merging <= 1'b0;
    end else begin
      state   <= state_next;
      merging <= merging_next;
    end
  end

endmodule

// ===== rtl/ltkm_dpath.sv =====
// datapath: leaf record memory, loser slot memory, replay registers and output register
`timescale 1ns / 1ps

module ltkm_dpath #(
  parameter int NUM_RUNS = ltkm_pkg::NUM_RUNS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ltkm_pkg::cmd_t                      cmd,
  output ltkm_pkg::sts_t                      sts,
  input  logic signed [ltkm_pkg::KEY_W-1:0]   key,
  input  logic signed [ltkm_pkg::INFO_W-1:0]  info,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ltkm_pkg::KEY_W-1:0]   out_key,
  output logic signed [ltkm_pkg::INFO_W-1:0]  out_info,
  output logic [ltkm_pkg::RUN_W-1:0]          src_run,
  output logic                                last
);

  localparam int KW    = ltkm_pkg::KEY_W;
  localparam int IW    = ltkm_pkg::INFO_W;
  localparam int RW    = ltkm_pkg::RUN_W;
  localparam int RECW  = KW + IW;
  localparam int LW    = $clog2(NUM_RUNS);
  localparam int SW    = $clog2(NUM_RUNS + 1);
  localparam logic [SW-1:0] VIRT      = SW'(NUM_RUNS);
  localparam logic [LW-1:0] LAST_LEAF = LW'(NUM_RUNS - 1);

  // storage
  logic [RECW-1:0] leaf_mem [NUM_RUNS];
  logic [SW-1:0]   slot_mem [NUM_RUNS];
  logic [RECW-1:0] leaf_rd;
  logic [SW-1:0]   slot_rd;
  logic [NUM_RUNS-1:0] slot_vld;

  // control state
  logic [LW-1:0] load_cnt;
  logic          building;
  logic [SW-1:0] winner;

  // replay registers
  logic [LW-1:0]           bld_idx;
  logic [SW-1:0]           champ;
  logic signed [KW-1:0]    champ_key;
  logic signed [IW-1:0]    champ_info;
  logic [LW-1:0]           node;
  logic [SW-1:0]           other;

  // combinational helpers
  logic                 champ_virt;
  logic                 other_virt;
  logic                 loses;
  logic [LW-1:0]        q_leaf;
  logic [LW-1:0]        wr_idx;
  logic [LW-1:0]        rd_idx;
  logic [LW:0]          leaf_sum;
  logic [LW-1:0]        node_up;
  logic [SW-1:0]        champ_step;
  logic signed [KW-1:0] other_key;

  assign champ_virt = (champ >= VIRT);
  assign other_virt = (other >= VIRT);
  assign other_key  = leaf_rd[RECW-1:IW];

  // climbing leaf loses on a strictly greater key or to the virtual leaf; the virtual leaf never loses
  assign loses = !champ_virt && (other_virt || (champ_key > other_key));
  assign champ_step = loses ? other : champ;

  // run whose leaf the next merging item replaces
  assign q_leaf = (winner >= VIRT) ? '0 : winner[LW-1:0];
  assign wr_idx = cmd.merging ? q_leaf : load_cnt;
  assign rd_idx = (slot_rd >= VIRT) ? '0 : slot_rd[LW-1:0];

  // first node above a leaf, and the parent of the current node
  assign leaf_sum = {1'b0, champ[LW-1:0]} + (LW+1)'(NUM_RUNS);
  assign node_up  = node >> 1;

  // status
  always_comb begin
    sts            = '0;
    sts.load_full  = (load_cnt == LAST_LEAF);
    sts.at_top     = (node_up == '0);
    sts.more_build = building && (bld_idx != '0);
    sts.is_end     = !champ_virt && (champ_key == ltkm_pkg::KEY_END);
    sts.out_free   = !out_valid || !out_stall;
  end

  // leaf record memory
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      leaf_mem[wr_idx] <= {key, info};
    end
    if (cmd.rd_champ) begin
      leaf_rd <= leaf_mem[champ[LW-1:0]];
    end else if (cmd.rd_other) begin
      leaf_rd <= leaf_mem[rd_idx];
    end
  end

  // loser slot memory, entries without a valid bit read as the virtual leaf
  always_ff @(posedge clk) begin
    if (cmd.step && loses) begin
      slot_mem[node] <= champ;
    end
    if (cmd.rd_slot) begin
      slot_rd <= slot_vld[node] ? slot_mem[node] : VIRT;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      load_cnt  <= '0;
      building  <= 1'b0;
      slot_vld  <= '0;
      winner    <= VIRT;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (cmd.merging) begin
          building <= 1'b0;
        end else if (load_cnt == LAST_LEAF) begin
          load_cnt <= '0;
          slot_vld <= '0;
          building <= 1'b1;
        end else begin
          load_cnt <= load_cnt + 1'b1;
        end
      end
      if (cmd.step) begin
        if (loses) begin
          slot_vld[node] <= 1'b1;
        end
        if (node_up == '0) begin
          winner <= champ_step;
        end
      end
      if (cmd.emit && sts.is_end) begin
        slot_vld <= '0;
        winner   <= VIRT;
        load_cnt <= '0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // replay datapath registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (cmd.merging) begin
        champ <= SW'(q_leaf);
      end else begin
        champ   <= SW'(LAST_LEAF);
        bld_idx <= LAST_LEAF;
      end
    end
    if (cmd.cap) begin
      champ_key  <= leaf_rd[RECW-1:IW];
      champ_info <= leaf_rd[IW-1:0];
      node       <= leaf_sum[LW:1];
    end
    if (cmd.rd_other) begin
      other <= slot_rd;
    end
    if (cmd.step) begin
      if (loses) begin
        champ_key  <= leaf_rd[RECW-1:IW];
        champ_info <= leaf_rd[IW-1:0];
      end
      node <= node_up;
      // next leaf of the initial build, else the level winner climbs on
      if ((node_up == '0) && building && (bld_idx != '0)) begin
        bld_idx <= bld_idx - 1'b1;
        champ   <= SW'(bld_idx - 1'b1);
      end else if (loses) begin
        champ <= other;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_key  <= champ_virt ? '0 : champ_key;
      out_info <= champ_virt ? '0 : champ_info;
      src_run  <= RW'(winner);
      last     <= sts.is_end;
    end
  end

endmodule
